>>> hdl/hmtd_pkg.sv
// Shared types, constants and list tables of the meter telegram decoder.
package hmtd_pkg;

    localparam int MAX_FRAME_BYTES = 255;
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int OFF_W = POS_W + 1;
    localparam int NUM_QTY = 14;
    localparam int MIN_FRAME = 18;

    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] TAG_COUNT  = 8'h02;
    localparam logic [7:0] TAG_VALUE  = 8'h06;
    localparam logic [7:0] TAG_STRING = 8'h09;
    localparam logic [7:0] LEN_HIGH_MASK = 8'h07;
    localparam logic [POS_W-1:0] CHECK_POS = POS_W'(17);
    localparam logic [POS_W-1:0] COUNT_PTR_POS = POS_W'(18);

    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_LIST1   = 3'd1;
    localparam logic [2:0] KIND_L2_1PH  = 3'd2;
    localparam logic [2:0] KIND_L2_3PH  = 3'd3;
    localparam logic [2:0] KIND_L3_1PH  = 3'd4;
    localparam logic [2:0] KIND_L3_3PH  = 3'd5;

    localparam logic [3:0] ITEM_STR = 4'd15;

    // Item sequence of each list as it appears in the telegram.
    localparam logic [3:0] LIST_ITEMS [6][18] = '{
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
          4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
          4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{ITEM_STR, ITEM_STR, ITEM_STR, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd7,
          4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{ITEM_STR, ITEM_STR, ITEM_STR, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
          4'd6, 4'd7, 4'd8, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{ITEM_STR, ITEM_STR, ITEM_STR, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd7,
          ITEM_STR, 4'd10, 4'd11, 4'd12, 4'd13, 4'd0, 4'd0, 4'd0, 4'd0},
        '{ITEM_STR, ITEM_STR, ITEM_STR, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
          4'd6, 4'd7, 4'd8, 4'd9, ITEM_STR, 4'd10, 4'd11, 4'd12, 4'd13}
    };
    localparam logic [4:0] LIST_LEN [6] = '{5'd0, 5'd1, 5'd9, 5'd13, 5'd14, 5'd18};

    // Quantities reported for each list, strings left out.
    localparam logic [3:0] QTY_LIST [6][14] = '{
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd7, 4'd10, 4'd11, 4'd12, 4'd13,
          4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
          4'd10, 4'd11, 4'd12, 4'd13}
    };
    localparam logic [3:0] QTY_CNT [6] = '{4'd1, 4'd1, 4'd6, 4'd10, 4'd10, 4'd14};

    // Finished frame handed from the parser to the result side.
    typedef struct packed {
        logic               valid;
        logic [2:0]         kind;
        logic [55:0]        stamp;
        logic [NUM_QTY-1:0] mask;
    } job_t;

    function automatic logic [2:0] kind_of(input logic [7:0] count);
        logic [2:0] k;
        unique case (count)
            8'd1:    k = KIND_LIST1;
            8'd9:    k = KIND_L2_1PH;
            8'd13:   k = KIND_L2_3PH;
            8'd14:   k = KIND_L3_1PH;
            8'd18:   k = KIND_L3_3PH;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/hmtd_front.sv
// Byte parser: frame checks, timestamp capture and tagged item walk.
module hmtd_front
    import hmtd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    input  logic        job_ready,
    output job_t        job,
    output logic [31:0] job_values [NUM_QTY]
);

    localparam logic [1:0] WK_HDR  = 2'd0;
    localparam logic [1:0] WK_CNT  = 2'd1;
    localparam logic [1:0] WK_ITEM = 2'd2;
    localparam logic [1:0] WK_DONE = 2'd3;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic [7:0]         b17_reg, b17_next;
    logic [55:0]        stamp_reg, stamp_next;
    logic [1:0]         wk_phase_reg, wk_phase_next;
    logic [OFF_W-1:0]   wk_off_reg, wk_off_next;
    logic [2:0]         wk_sub_reg, wk_sub_next;
    logic [4:0]         wk_idx_reg, wk_idx_next;
    logic [2:0]         wk_kind_reg, wk_kind_next;
    logic               tagok_reg, tagok_next;
    logic [7:0]         skip_reg, skip_next;
    logic [23:0]        shift_reg, shift_next;
    logic [NUM_QTY-1:0] mask_reg, mask_next;
    logic [7:0]         cnt_stage_reg, cnt_stage_next;
    logic               cnt_new_reg, cnt_new_next;
    logic [7:0]         kept_count_reg, kept_count_next;
    logic               commit_reg, commit_next;
    logic [31:0]        stage_reg [NUM_QTY];

    logic               stage_we;
    logic [3:0]         stage_idx;
    logic [31:0]        stage_data;
    logic [3:0]         item;
    logic [7:0]         b17_eff, eff_count, new_count;
    logic [10:0]        len_field;
    logic               frame_ok, hit, take;
    logic [OFF_W:0]     off_sum;

    function automatic logic [OFF_W-1:0] sat_off(input logic [OFF_W:0] s);
        return s[OFF_W] ? {OFF_W{1'b1}} : s[OFF_W-1:0];
    endfunction

    assign take      = commit_reg && job_ready;
    assign eff_count = cnt_new_reg ? cnt_stage_reg : kept_count_reg;
    assign b17_eff   = (pos_reg == CHECK_POS) ? in_byte : b17_reg;
    assign len_field = {b1_reg[2:0] & LEN_HIGH_MASK[2:0], b2_reg};
    assign item      = LIST_ITEMS[wk_kind_reg][wk_idx_reg];
    assign hit       = (wk_phase_reg == WK_CNT || wk_phase_reg == WK_ITEM)
                       && ({1'b0, pos_reg} == wk_off_reg);

    // The closing byte is the last byte of the frame itself.
    assign frame_ok = (pos_reg < POS_W'(MAX_FRAME_BYTES))
                      && (pos_reg >= POS_W'(MIN_FRAME - 1))
                      && (in_byte == FLAG_BYTE) && (b0_reg == FLAG_BYTE)
                      && (b17_eff == TAG_STRING)
                      && (len_field == 11'(pos_reg - POS_W'(1)));

    always_comb begin
        pos_next        = pos_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        b2_next         = b2_reg;
        b17_next        = b17_reg;
        stamp_next      = stamp_reg;
        wk_phase_next   = wk_phase_reg;
        wk_off_next     = wk_off_reg;
        wk_sub_next     = wk_sub_reg;
        wk_idx_next     = wk_idx_reg;
        wk_kind_next    = wk_kind_reg;
        tagok_next      = tagok_reg;
        skip_next       = skip_reg;
        shift_next      = shift_reg;
        mask_next       = mask_reg;
        cnt_stage_next  = cnt_stage_reg;
        cnt_new_next    = cnt_new_reg;
        kept_count_next = kept_count_reg;
        commit_next     = commit_reg && !take;
        stage_we        = 1'b0;
        stage_idx       = item;
        stage_data      = {shift_reg, in_byte};
        new_count       = tagok_reg ? in_byte : kept_count_reg;
        off_sum         = '0;

        if (take) begin
            kept_count_next = eff_count;
        end

        if (in_fire) begin
            if (pos_reg < POS_W'(MAX_FRAME_BYTES)) begin
                pos_next = pos_reg + POS_W'(1);
            end else begin
                pos_next = POS_W'(MAX_FRAME_BYTES + 1);
            end

            unique case (pos_reg)
                POS_W'(0):  b0_next = in_byte;
                POS_W'(1):  b1_next = in_byte;
                POS_W'(2):  b2_next = in_byte;
                CHECK_POS:  b17_next = in_byte;
                POS_W'(19): stamp_next[55:48] = in_byte;
                POS_W'(20): stamp_next[47:40] = in_byte;
                POS_W'(21): stamp_next[39:32] = in_byte;
                POS_W'(22): stamp_next[31:24] = in_byte;
                POS_W'(24): stamp_next[23:16] = in_byte;
                POS_W'(25): stamp_next[15:8]  = in_byte;
                POS_W'(26): stamp_next[7:0]   = in_byte;
                default: ;
            endcase

            if (pos_reg == '0) begin
                // First byte of a new frame clears what the last one left.
                stamp_next    = '0;
                wk_phase_next = WK_HDR;
                mask_next     = '0;
                skip_next     = '0;
                cnt_new_next  = 1'b0;
            end else if (wk_phase_reg == WK_HDR && pos_reg == COUNT_PTR_POS) begin
                off_sum       = (OFF_W + 1)'(19) + (OFF_W + 1)'(in_byte);
                wk_off_next   = sat_off(off_sum);
                wk_phase_next = WK_CNT;
                wk_sub_next   = '0;
            end else if (hit) begin
                off_sum     = {1'b0, wk_off_reg} + (OFF_W + 1)'(1);
                wk_off_next = sat_off(off_sum);
                if (wk_phase_reg == WK_CNT) begin
                    if (wk_sub_reg == '0) begin
                        tagok_next  = (in_byte == TAG_COUNT);
                        wk_sub_next = 3'd1;
                    end else begin
                        if (tagok_reg) begin
                            cnt_stage_next = in_byte;
                            cnt_new_next   = 1'b1;
                        end
                        wk_kind_next  = kind_of(new_count);
                        wk_idx_next   = '0;
                        wk_sub_next   = '0;
                        wk_phase_next = (kind_of(new_count) == KIND_UNKNOWN) ? WK_DONE
                                                                             : WK_ITEM;
                    end
                end else if (item == ITEM_STR) begin
                    if (wk_sub_reg == '0) begin
                        tagok_next  = (in_byte == TAG_STRING);
                        wk_sub_next = 3'd1;
                    end else begin
                        skip_next   = tagok_reg ? in_byte : skip_reg;
                        off_sum     = {1'b0, wk_off_reg} + (OFF_W + 1)'(1)
                                      + (OFF_W + 1)'(skip_next);
                        wk_off_next = sat_off(off_sum);
                        wk_sub_next = '0;
                        wk_idx_next = wk_idx_reg + 5'd1;
                        if (wk_idx_reg + 5'd1 == LIST_LEN[wk_kind_reg]) begin
                            wk_phase_next = WK_DONE;
                        end
                    end
                end else begin
                    if (wk_sub_reg == '0) begin
                        tagok_next = (in_byte == TAG_VALUE);
                    end else begin
                        shift_next = {shift_reg[15:0], in_byte};
                    end
                    wk_sub_next = wk_sub_reg + 3'd1;
                    if (wk_sub_reg == 3'd4) begin
                        stage_we        = tagok_reg;
                        if (tagok_reg) begin
                            mask_next[item] = 1'b1;
                        end
                        wk_sub_next = '0;
                        wk_idx_next = wk_idx_reg + 5'd1;
                        if (wk_idx_reg + 5'd1 == LIST_LEN[wk_kind_reg]) begin
                            wk_phase_next = WK_DONE;
                        end
                    end
                end
            end

            if (in_end) begin
                pos_next    = '0;
                commit_next = frame_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            b0_reg         <= '0;
            b1_reg         <= '0;
            b2_reg         <= '0;
            b17_reg        <= '0;
            stamp_reg      <= '0;
            wk_phase_reg   <= WK_HDR;
            wk_off_reg     <= '0;
            wk_sub_reg     <= '0;
            wk_idx_reg     <= '0;
            wk_kind_reg    <= KIND_UNKNOWN;
            tagok_reg      <= 1'b0;
            skip_reg       <= '0;
            shift_reg      <= '0;
            mask_reg       <= '0;
            cnt_stage_reg  <= '0;
            cnt_new_reg    <= 1'b0;
            kept_count_reg <= '0;
            commit_reg     <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            b0_reg         <= b0_next;
            b1_reg         <= b1_next;
            b2_reg         <= b2_next;
            b17_reg        <= b17_next;
            stamp_reg      <= stamp_next;
            wk_phase_reg   <= wk_phase_next;
            wk_off_reg     <= wk_off_next;
            wk_sub_reg     <= wk_sub_next;
            wk_idx_reg     <= wk_idx_next;
            wk_kind_reg    <= wk_kind_next;
            tagok_reg      <= tagok_next;
            skip_reg       <= skip_next;
            shift_reg      <= shift_next;
            mask_reg       <= mask_next;
            cnt_stage_reg  <= cnt_stage_next;
            cnt_new_reg    <= cnt_new_next;
            kept_count_reg <= kept_count_next;
            commit_reg     <= commit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_we) begin
            stage_reg[stage_idx] <= stage_data;
        end
    end

    assign job.valid  = commit_reg;
    assign job.kind   = kind_of(eff_count);
    assign job.stamp  = stamp_reg;
    assign job.mask   = mask_reg;
    assign job_values = stage_reg;

endmodule

>>> hdl/hmtd_back.sv
// Result side: applies a finished frame to the kept values and emits its list.
module hmtd_back
    import hmtd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  job_t         job,
    input  logic [31:0]  job_values [NUM_QTY],
    output logic         job_ready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,
    output logic [6:0]   m_tuser,
    output logic         m_tlast
);

    logic [31:0] kept_reg [NUM_QTY];
    logic        busy_reg, busy_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [55:0] stamp_reg, stamp_next;
    logic        vld_reg, vld_next;
    logic [87:0] data_reg, data_next;
    logic [6:0]  user_reg, user_next;
    logic        last_reg, last_next;
    logic        adv, take, fin;
    logic [3:0]  qty;
    logic [31:0] val;

    assign job_ready = !busy_reg;
    assign take      = job.valid && !busy_reg;
    assign adv       = !vld_reg || m_tready;
    assign qty       = QTY_LIST[kind_reg][cnt_reg];
    assign val       = (kind_reg == KIND_UNKNOWN) ? 32'd0 : kept_reg[qty];
    assign fin       = (cnt_reg + 4'd1 == QTY_CNT[kind_reg]);

    always_comb begin
        busy_next  = busy_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        stamp_next = stamp_reg;
        vld_next   = vld_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (take) begin
            busy_next  = 1'b1;
            kind_next  = job.kind;
            cnt_next   = '0;
            stamp_next = job.stamp;
            // A result still on the bus may be taken while the new frame loads.
            if (adv) begin
                vld_next = 1'b0;
            end
        end else if (busy_reg && adv) begin
            vld_next  = 1'b1;
            data_next = {stamp_reg[7:0], stamp_reg[15:8], stamp_reg[23:16],
                         stamp_reg[31:24], stamp_reg[39:32], stamp_reg[55:40], val};
            user_next = {qty, kind_reg};
            last_next = fin;
            cnt_next  = cnt_reg + 4'd1;
            busy_next = !fin;
        end else if (adv) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            kind_reg <= KIND_UNKNOWN;
            cnt_reg  <= '0;
            vld_reg  <= 1'b0;
            for (int i = 0; i < NUM_QTY; i++) begin
                kept_reg[i] <= '0;
            end
        end else begin
            busy_reg <= busy_next;
            kind_reg <= kind_next;
            cnt_reg  <= cnt_next;
            vld_reg  <= vld_next;
            if (take && job.kind != KIND_UNKNOWN) begin
                for (int i = 0; i < NUM_QTY; i++) begin
                    if (job.mask[i]) begin
                        kept_reg[i] <= job_values[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        stamp_reg <= stamp_next;
        data_reg  <= data_next;
        user_reg  <= user_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

>>> hdl/han_meter_telegram_decoder_core.sv
// Top level of the meter telegram decoder: byte parser and result emitter.
//
// Usage: received meter-port bytes enter on the slave stream, one byte per
// transaction, with s_tlast set on the last byte of a burst. The burst is
// judged as one frame when that byte arrives. A valid frame yields one
// result transaction per reported quantity on the master stream, in
// ascending quantity order, each with the frame's header timestamp; m_tlast
// marks the final one and m_tuser says which list and quantity it carries.
// A frame with an unknown item count gives a single result of kind 0.
// Invalid frames give nothing.
// Throughput is one byte per cycle while s_tready is high. The first result
// leaves once the closing byte is accepted and the frame has been committed
// and taken by the emitter, then one result per cycle while the receiver
// takes them, and input continues while results drain. Only if
// the receiver stalls so long that a second valid frame finishes before the
// first frame's list is out does s_tready drop, for one handoff, until the
// emitter takes the new frame. Reset clears all kept quantities, the kept
// item count and timestamp, and the byte position.
module han_meter_telegram_decoder_core
    import hmtd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] value, [47:32] year, [55:48] month, [63:56] day,
    // [71:64] hour, [79:72] minute, [87:80] second
    output logic [87:0] m_tdata,
    output logic [6:0]  m_tuser,   // [2:0] list_kind, [6:3] quantity
    output logic        m_tlast    // last
);

    job_t        job;
    logic [31:0] job_values [NUM_QTY];
    logic        job_ready;

    // A finished frame waits in the parser's staging registers until the
    // emitter is free; input only stalls while such a frame is still waiting.
    assign s_tready = !job.valid || job_ready;

    hmtd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (s_tvalid && s_tready),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .job_ready  (job_ready),
        .job        (job),
        .job_values (job_values)
    );

    hmtd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job        (job),
        .job_values (job_values),
        .job_ready  (job_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> sim/tb_han_meter_telegram_decoder_core.sv
// Self-checking testbench for the meter telegram decoder core.
`timescale 1ns / 100ps

module tb_han_meter_telegram_decoder_core;
    import hmtd_pkg::*;

    // One expected result transaction on the master stream.
    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  qty;
        logic [31:0] value;
        logic [55:0] stamp;
        logic        last;
    } meter_result_t;

    typedef logic [7:0] byte_q_t[$];

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [6:0]  m_tuser;
    logic        m_tlast;

    // Predictor state: the bytes of the burst under way and the kept values.
    logic [7:0]  burst_bytes[$];
    logic [31:0] kept_qty[NUM_QTY];
    logic [7:0]  kept_count;
    logic [55:0] kept_stamp;
    meter_result_t pending_results[$];

    int mismatches = 0;
    int results_seen = 0;
    int frames_sent = 0;
    int bytes_sent = 0;
    int cycles = 0;
    int rx_wait = 0;
    bit hold_off = 1'b0;

    han_meter_telegram_decoder_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] frame_byte(int idx, int len);
        if (idx < len) return burst_bytes[idx];
        return 8'h00;
    endfunction

    // Judge the closed burst as a frame and queue the results it yields.
    function automatic void judge_burst();
        int len;
        int off;
        logic [7:0] skip;
        logic [2:0] kind;
        logic [3:0] item;
        int nres;
        meter_result_t r;
        len = burst_bytes.size();
        if (len < MIN_FRAME || len > MAX_FRAME_BYTES) return;
        if (burst_bytes[0] != FLAG_BYTE || burst_bytes[len-1] != FLAG_BYTE ||
            burst_bytes[17] != TAG_STRING) return;
        if ({burst_bytes[1][2:0], burst_bytes[2]} != 11'(len - 2)) return;
        kept_stamp = {frame_byte(19, len), frame_byte(20, len), frame_byte(21, len),
                      frame_byte(22, len), frame_byte(24, len), frame_byte(25, len),
                      frame_byte(26, len)};
        off = 19 + burst_bytes[18];
        if (off + 1 < len && burst_bytes[off] == TAG_COUNT) kept_count = burst_bytes[off+1];
        off += 2;
        case (kept_count)
            8'd1:    kind = KIND_LIST1;
            8'd9:    kind = KIND_L2_1PH;
            8'd13:   kind = KIND_L2_3PH;
            8'd14:   kind = KIND_L3_1PH;
            8'd18:   kind = KIND_L3_3PH;
            default: kind = KIND_UNKNOWN;
        endcase
        r.stamp = kept_stamp;
        if (kind == KIND_UNKNOWN) begin
            r.kind = KIND_UNKNOWN; r.qty = 0; r.value = 0; r.last = 1'b1;
            pending_results.push_back(r);
            return;
        end
        skip = 0;
        for (int i = 0; i < LIST_LEN[kind]; i++) begin
            item = LIST_ITEMS[kind][i];
            if (item == ITEM_STR) begin
                if (off + 1 < len && burst_bytes[off] == TAG_STRING) skip = burst_bytes[off+1];
                off += 2 + skip;
            end else begin
                if (off + 4 < len && burst_bytes[off] == TAG_VALUE)
                    kept_qty[item] = {burst_bytes[off+1], burst_bytes[off+2],
                                      burst_bytes[off+3], burst_bytes[off+4]};
                off += 5;
            end
        end
        nres = 0;
        for (int i = 0; i < LIST_LEN[kind]; i++) begin
            item = LIST_ITEMS[kind][i];
            if (item != ITEM_STR) begin
                r.kind = kind; r.qty = item; r.value = kept_qty[item]; r.last = 1'b0;
                pending_results.push_back(r);
                nres++;
            end
        end
        pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    // Send one byte; the predictor runs when the transaction is accepted.
    task automatic send_byte(logic [7:0] data, logic close);
        int gap;
        gap = (hold_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= close;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (burst_bytes.size() < MAX_FRAME_BYTES + 1) burst_bytes.push_back(data);
        if (close) begin
            judge_burst();
            burst_bytes.delete();
        end
    endtask

    task automatic send_burst(byte_q_t bytes);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
        frames_sent++;
    endtask

    // Receiver: drawn stalls and the field-by-field compare.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                meter_result_t e;
                meter_result_t a;
                a.kind = m_tuser[2:0]; a.qty = m_tuser[6:3]; a.value = m_tdata[31:0];
                a.stamp = {m_tdata[47:32], m_tdata[55:48], m_tdata[63:56],
                           m_tdata[71:64], m_tdata[79:72], m_tdata[87:80]};
                a.last = m_tlast;
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result kind=%0d qty=%0d",
                                                   a.kind, a.qty);
                end else begin
                    e = pending_results.pop_front();
                    if (a.kind != e.kind || a.qty != e.qty || a.value != e.value ||
                        a.stamp != e.stamp || a.last != e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: exp kind=%0d qty=%0d val=%h stamp=%h ",
                                      "last=%b, got kind=%0d qty=%0d val=%h stamp=%h last=%b"},
                                     e.kind, e.qty, e.value, e.stamp, e.last,
                                     a.kind, a.qty, a.value, a.stamp, a.last);
                    end
                end
                rx_wait = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 18);
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Build a frame of the given item count with random content; break_tags corrupts some tags and may cut it short.
    function automatic byte_q_t build_frame(int count, int str_len, bit break_tags);
        byte_q_t f;
        logic [2:0] kind;
        int len;
        f.push_back(FLAG_BYTE); f.push_back(8'h00); f.push_back(8'h00);
        for (int i = 3; i < 17; i++) f.push_back(8'($urandom));
        f.push_back(TAG_STRING);
        f.push_back(8'd8);                       // offset to the count tag
        for (int i = 0; i < 8; i++) f.push_back(8'($urandom));
        f.push_back(TAG_COUNT); f.push_back(8'(count));
        kind = kind_of(8'(count));
        if (kind != KIND_UNKNOWN) begin
            for (int i = 0; i < LIST_LEN[kind]; i++) begin
                if (LIST_ITEMS[kind][i] == ITEM_STR) begin
                    f.push_back((break_tags && $urandom_range(0, 3) == 0) ? 8'h05 : TAG_STRING);
                    f.push_back(8'(str_len));
                    for (int j = 0; j < str_len; j++) f.push_back(8'($urandom));
                end else begin
                    f.push_back((break_tags && $urandom_range(0, 3) == 0) ? 8'h07 : TAG_VALUE);
                    for (int j = 0; j < 4; j++) f.push_back(8'($urandom));
                end
            end
        end
        if (break_tags && $urandom_range(0, 1)) f = f[0:$urandom_range(20, f.size() - 1)];
        f.push_back(FLAG_BYTE);
        len = f.size();
        f[1] = {5'($urandom), 3'(len - 2 >> 8)};
        f[2] = 8'(len - 2);
        return f;
    endfunction

    // Shortest valid frame: the count pointer leads past the end, so the kept
    // count is reused and the timestamp reads as zero.
    function automatic byte_q_t min_frame();
        byte_q_t f;
        f.push_back(FLAG_BYTE); f.push_back(8'h00); f.push_back(8'd17);
        for (int i = 3; i < 17; i++) f.push_back(8'($urandom));
        f.push_back(TAG_STRING);
        f.push_back(FLAG_BYTE);
        return f;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic test_each_list();
        send_burst(build_frame(7, 0, 1'b0));
        send_burst(build_frame(1, 0, 1'b0));
        send_burst(build_frame(9, 0, 1'b0));
        wait_drained();
    endtask

    task automatic test_bad_frames();
        byte_q_t f;
        f = min_frame();
        f[2] = 8'd18; send_burst(f);              // length field off by one
        f.delete();
        for (int i = 0; i < 6; i++) f.push_back(FLAG_BYTE);
        send_burst(f);                            // shorter than minimum
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < 3; i++) send_burst(min_frame());
        wait_drained();
    endtask

    initial begin
        foreach (kept_qty[i]) kept_qty[i] = '0;
        kept_count = '0;
        kept_stamp = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_each_list();
        test_bad_frames();
        test_backpressure();
        $display("Sent %0d bursts (%0d bytes): unknown, list-1 and list-2 frames,",
                 frames_sent, bytes_sent);
        $display("rejected bursts and a long receiver stall; %0d results, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
